// ----- hw/rtl/pr_pkg.sv -----
`default_nettype none

package pr_pkg;

   // Storage sizes.
   localparam int MAX_NODES = 1024;
   localparam int MAX_EDGES = 8192;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = NODE_W + 1;
   localparam int EDGE_AW   = $clog2(MAX_EDGES);
   localparam int ECNT_W    = EDGE_AW + 1;
   localparam int EDGE_W    = 2 * NODE_W;
   localparam int DEG_W     = ECNT_W;

   // Field and register widths.
   localparam int RANK_W     = 32;
   localparam int ACC_W      = RANK_W + EDGE_AW + 1;
   localparam int DANG_W     = RANK_W + NODE_W + 1;
   localparam int DIV_W      = DANG_W;
   localparam int NUM_W      = 11;
   localparam int ITER_W     = 16;
   localparam int PASS_W     = 17;
   localparam int THR_W      = 64;
   localparam int PROD_W     = 2 * RANK_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // Fixed-point constants, unsigned Q2.30.
   localparam logic [RANK_W-1:0] ONE_Q30  = 32'h4000_0000;
   localparam logic [RANK_W-1:0] DAMP_Q30 = 32'd912680550;
   localparam logic [PROD_W-1:0] HALF_LSB = 64'h0000_0000_2000_0000;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_RUN   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_NODES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ITER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/pr_req_if.sv -----
`default_nettype none

interface pr_req_if import pr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [NODE_W-1:0] source_node;
   logic [NODE_W-1:0] target_node;

   modport source (output valid, op, source_node, target_node, input ready);
   modport sink   (input valid, op, source_node, target_node, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pr_rsp_if.sv -----
`default_nettype none

interface pr_rsp_if import pr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RANK_W-1:0] rank_value;
   logic [PASS_W-1:0] iterations_done;
   logic              converged;
   logic [1:0]        status;

   modport source (output valid, rank_value, iterations_done, converged, status,
                   input ready);
   modport sink   (input valid, rank_value, iterations_done, converged, status,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pagerank_power_iteration_top.sv -----
`default_nettype none

// PageRank by power iteration with dangling nodes, ranks in unsigned Q2.30.
// Items on the req channel carry an op: clear graph, add edge, run ranking
// or read rank; each item gives exactly one item on the rsp channel, and the
// block takes one item at a time. Any item may wait for the rsp slot before
// it is done. A clear item rewrites the whole out-degree memory, one node per
// cycle; the same sweep runs after reset, before the first item is taken. A
// run item sets up with two divisions and N rank writes, then each pass
// clears the accumulators, reads every stored edge and spreads the share of
// each used edge through the shared serial divider, divides the dangling
// sum, and updates each node, where one shared 32x32 multiplier forms the
// damped rank and then the squared change. Up to max_iterations+1 passes
// run; they stop early once the summed squared change is at or below
// threshold.
module pagerank_power_iteration_top import pr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pr_req_if.sink                     req_chan,
   pr_rsp_if.source                   rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Sequencer states.
   localparam logic [4:0] S_WIPE     = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_ADD_WR   = 5'd2;
   localparam logic [4:0] S_READ     = 5'd3;
   localparam logic [4:0] S_DIV_INIT = 5'd4;
   localparam logic [4:0] S_DIV_TEL  = 5'd5;
   localparam logic [4:0] S_INIT_WR  = 5'd6;
   localparam logic [4:0] S_CLR_RD   = 5'd7;
   localparam logic [4:0] S_CLR_ACC  = 5'd8;
   localparam logic [4:0] S_EDGE_RD  = 5'd9;
   localparam logic [4:0] S_EDGE_SRC = 5'd10;
   localparam logic [4:0] S_EDGE_CHK = 5'd11;
   localparam logic [4:0] S_EDGE_DIV = 5'd12;
   localparam logic [4:0] S_DIV_DANG = 5'd13;
   localparam logic [4:0] S_UPD_RD   = 5'd14;
   localparam logic [4:0] S_UPD_MUL  = 5'd15;
   localparam logic [4:0] S_UPD_NEW  = 5'd16;
   localparam logic [4:0] S_UPD_SQ   = 5'd17;
   localparam logic [4:0] S_UPD_ACC  = 5'd18;
   localparam logic [4:0] S_PASS_END = 5'd19;
   localparam logic [4:0] S_RESP     = 5'd20;

   localparam logic [CNT_W-1:0]  LAST_NODE = CNT_W'(MAX_NODES - 1);
   localparam logic [ECNT_W-1:0] EDGE_CAP  = ECNT_W'(MAX_EDGES);

   // Configuration registers.
   logic [NUM_W-1:0]  num_nodes_ff;
   logic [ITER_W-1:0] max_iter_ff;
   logic [THR_W-1:0]  threshold_ff;

   // Sequencer and working registers.
   logic [4:0]         state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [ECNT_W-1:0]  eidx_ff, eidx_in;
   logic [ECNT_W-1:0]  edge_count_ff, edge_count_in;
   logic [NODE_W-1:0]  src_ff, src_in;
   logic [NODE_W-1:0]  tgt_ff, tgt_in;
   logic               wipe_rsp_ff, wipe_rsp_in;
   logic [RANK_W-1:0]  init_ff, init_in;
   logic [RANK_W-1:0]  teleport_ff, teleport_in;
   logic [DANG_W-1:0]  dang_ff, dang_in;
   logic [THR_W-1:0]   delta_ff, delta_in;
   logic [RANK_W-1:0]  old_ff, old_in;
   logic [RANK_W-1:0]  new_ff, new_in;
   logic [PROD_W-1:0]  prod_ff;
   logic [PASS_W-1:0]  passes_ff, passes_in;
   logic [PASS_W-1:0]  last_iter_ff, last_iter_in;
   logic               last_conv_ff, last_conv_in;
   logic [RANK_W-1:0]  res_rank_ff, res_rank_in;
   logic [1:0]         res_status_ff, res_status_in;

   // Result slot.
   logic               rsp_valid_ff;
   logic [RANK_W-1:0]  rsp_rank_ff;
   logic [PASS_W-1:0]  rsp_iter_ff;
   logic               rsp_conv_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_load;

   // Memory ports.
   logic               edge_we;
   logic [EDGE_AW-1:0] edge_raddr;
   logic [EDGE_W-1:0]  edge_rdata;
   logic               deg_we;
   logic [NODE_W-1:0]  deg_waddr, deg_raddr;
   logic [DEG_W-1:0]   deg_wdata, deg_rdata;
   logic               rank_we;
   logic [NODE_W-1:0]  rank_waddr, rank_raddr;
   logic [RANK_W-1:0]  rank_wdata, rank_rdata;
   logic               acc_we;
   logic [NODE_W-1:0]  acc_waddr, acc_raddr;
   logic [ACC_W-1:0]   acc_wdata, acc_rdata;

   // Shared divider and multiplier.
   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic [DEG_W-1:0]   div_divisor;
   logic               div_done;
   logic [DIV_W-1:0]   div_quotient;
   logic [RANK_W-1:0]  mul_a, mul_b;

   // Derived values.
   logic [CNT_W-1:0]   n_eff;
   logic [CNT_W-1:0]   n_half;
   logic               req_accept;
   logic               src_out, tgt_out;
   logic [NODE_W-1:0]  edge_src, edge_tgt;
   logic               edge_used;
   logic [ACC_W:0]     upd_sum;
   logic [RANK_W-1:0]  upd_sat;
   logic [PROD_W-1:0]  rounded;
   logic [RANK_W+1:0]  damped;
   logic [RANK_W-1:0]  new_rank;
   logic [RANK_W-1:0]  rank_diff;
   logic [THR_W:0]     delta_sum;
   logic               delta_ok;
   logic               node_last;

   // The node count in use: zero acts as one, anything past the store as full.
   always_comb begin
      priority if (num_nodes_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (CNT_W'(num_nodes_ff) > CNT_W'(MAX_NODES)) begin
         n_eff = CNT_W'(MAX_NODES);
      end else begin
         n_eff = CNT_W'(num_nodes_ff);
      end
   end
   assign n_half    = n_eff >> 1;
   assign node_last = idx_ff == n_eff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff <= NUM_W'(1024);
         max_iter_ff  <= ITER_W'(100);
         threshold_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_NUM_NODES: num_nodes_ff <= csr_wdata[NUM_W-1:0];
            REG_MAX_ITER:  max_iter_ff  <= csr_wdata[ITER_W-1:0];
            REG_THRESHOLD: threshold_ff <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = state_ff == S_IDLE;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign src_out        = {1'b0, req_chan.source_node} >= n_eff;
   assign tgt_out        = {1'b0, req_chan.target_node} >= n_eff;

   assign edge_src  = edge_rdata[EDGE_W-1:NODE_W];
   assign edge_tgt  = edge_rdata[NODE_W-1:0];
   assign edge_used = ({1'b0, src_ff} < n_eff) && (deg_rdata != '0)
                      && ({1'b0, tgt_ff} < n_eff);

   // Rank update arithmetic.
   assign upd_sum   = {1'b0, acc_rdata} + (ACC_W+1)'(dang_ff);
   assign upd_sat   = (upd_sum > (ACC_W+1)'({RANK_W{1'b1}})) ? {RANK_W{1'b1}}
                                                              : upd_sum[RANK_W-1:0];
   assign rounded   = prod_ff + HALF_LSB;
   assign damped    = (RANK_W+2)'(rounded[PROD_W-1:30]) + (RANK_W+2)'(teleport_ff);
   assign new_rank  = (damped[RANK_W+1:RANK_W] != 2'b00) ? {RANK_W{1'b1}}
                                                         : damped[RANK_W-1:0];
   assign rank_diff = (old_ff >= new_ff) ? old_ff - new_ff : new_ff - old_ff;
   assign delta_sum = {1'b0, delta_ff} + {1'b0, prod_ff};
   assign delta_ok  = delta_ff <= threshold_ff;

   // Multiplier operands: damping in one step, the squared change in another.
   always_comb begin
      if (state_ff == S_UPD_SQ) begin
         mul_a = rank_diff;
         mul_b = rank_diff;
      end else begin
         mul_a = upd_sat;
         mul_b = DAMP_Q30;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Read addresses.
   always_comb begin
      edge_raddr = eidx_ff[EDGE_AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            rank_raddr = req_chan.source_node;
            deg_raddr  = req_chan.source_node;
         end
         S_EDGE_SRC: begin
            rank_raddr = edge_src;
            deg_raddr  = edge_src;
         end
         default: begin
            rank_raddr = idx_ff[NODE_W-1:0];
            deg_raddr  = idx_ff[NODE_W-1:0];
         end
      endcase
      acc_raddr = (state_ff == S_EDGE_DIV) ? tgt_ff : idx_ff[NODE_W-1:0];
   end

   // Write ports.
   assign edge_we    = state_ff == S_ADD_WR;
   assign deg_we     = (state_ff == S_WIPE) || (state_ff == S_ADD_WR);
   assign deg_waddr  = (state_ff == S_WIPE) ? idx_ff[NODE_W-1:0] : src_ff;
   assign deg_wdata  = (state_ff == S_WIPE) ? '0 : deg_rdata + 1'b1;
   assign rank_we    = (state_ff == S_INIT_WR) || (state_ff == S_UPD_NEW);
   assign rank_waddr = idx_ff[NODE_W-1:0];
   assign rank_wdata = (state_ff == S_INIT_WR) ? init_ff : new_rank;
   assign acc_we     = (state_ff == S_CLR_ACC) || ((state_ff == S_EDGE_DIV) && div_done);
   assign acc_waddr  = (state_ff == S_CLR_ACC) ? idx_ff[NODE_W-1:0] : tgt_ff;
   assign acc_wdata  = (state_ff == S_CLR_ACC) ? '0
                       : acc_rdata + ACC_W'(div_quotient[RANK_W-1:0]);

   // Divider requests.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIV_W'(ONE_Q30) + DIV_W'(n_half);
      div_divisor  = DEG_W'(n_eff);
      unique case (state_ff)
         S_IDLE: begin
            div_start = req_accept && (op_type'(req_chan.op) == OP_RUN);
         end
         S_DIV_INIT: begin
            div_start    = div_done;
            div_dividend = DIV_W'(ONE_Q30 - DAMP_Q30) + DIV_W'(n_half);
         end
         S_EDGE_CHK: begin
            div_start    = edge_used;
            div_dividend = DIV_W'(rank_rdata);
            div_divisor  = deg_rdata;
         end
         S_EDGE_RD: begin
            div_start    = eidx_ff == edge_count_ff;
            div_dividend = DIV_W'(dang_ff);
         end
         default: ;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      eidx_in       = eidx_ff;
      edge_count_in = edge_count_ff;
      src_in        = src_ff;
      tgt_in        = tgt_ff;
      wipe_rsp_in   = wipe_rsp_ff;
      init_in       = init_ff;
      teleport_in   = teleport_ff;
      dang_in       = dang_ff;
      delta_in      = delta_ff;
      old_in        = old_ff;
      new_in        = new_ff;
      passes_in     = passes_ff;
      last_iter_in  = last_iter_ff;
      last_conv_in  = last_conv_ff;
      res_rank_in   = res_rank_ff;
      res_status_in = res_status_ff;
      rsp_load      = 1'b0;
      unique case (state_ff)
         S_WIPE: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_NODE) begin
               state_in = wipe_rsp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               src_in        = req_chan.source_node;
               tgt_in        = req_chan.target_node;
               res_rank_in   = '0;
               res_status_in = ST_OK;
               unique case (op_type'(req_chan.op))
                  OP_CLEAR: begin
                     edge_count_in = '0;
                     idx_in        = '0;
                     wipe_rsp_in   = 1'b1;
                     state_in      = S_WIPE;
                  end
                  OP_ADD: begin
                     priority if (src_out || tgt_out) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_RESP;
                     end else if (edge_count_ff >= EDGE_CAP) begin
                        res_status_in = ST_FULL;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_ADD_WR;
                     end
                  end
                  OP_RUN: begin
                     state_in = S_DIV_INIT;
                  end
                  OP_READ: begin
                     if (src_out) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ADD_WR: begin
            edge_count_in = edge_count_ff + 1'b1;
            state_in      = S_RESP;
         end
         S_READ: begin
            res_rank_in = rank_rdata;
            state_in    = S_RESP;
         end
         S_DIV_INIT: begin
            if (div_done) begin
               init_in  = div_quotient[RANK_W-1:0];
               state_in = S_DIV_TEL;
            end
         end
         S_DIV_TEL: begin
            if (div_done) begin
               teleport_in = div_quotient[RANK_W-1:0];
               idx_in      = '0;
               state_in    = S_INIT_WR;
            end
         end
         S_INIT_WR: begin
            if (node_last) begin
               idx_in    = '0;
               dang_in   = '0;
               delta_in  = '0;
               passes_in = '0;
               state_in  = S_CLR_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CLR_RD: begin
            state_in = S_CLR_ACC;
         end
         S_CLR_ACC: begin
            if (deg_rdata == '0) begin
               dang_in = dang_ff + DANG_W'(rank_rdata);
            end
            if (node_last) begin
               eidx_in  = '0;
               state_in = S_EDGE_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_CLR_RD;
            end
         end
         S_EDGE_RD: begin
            state_in = (eidx_ff == edge_count_ff) ? S_DIV_DANG : S_EDGE_SRC;
         end
         S_EDGE_SRC: begin
            src_in   = edge_src;
            tgt_in   = edge_tgt;
            state_in = S_EDGE_CHK;
         end
         S_EDGE_CHK: begin
            if (edge_used) begin
               state_in = S_EDGE_DIV;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = S_EDGE_RD;
            end
         end
         S_EDGE_DIV: begin
            if (div_done) begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = S_EDGE_RD;
            end
         end
         S_DIV_DANG: begin
            if (div_done) begin
               dang_in  = div_quotient;
               idx_in   = '0;
               state_in = S_UPD_RD;
            end
         end
         S_UPD_RD: begin
            state_in = S_UPD_MUL;
         end
         S_UPD_MUL: begin
            old_in   = rank_rdata;
            state_in = S_UPD_NEW;
         end
         S_UPD_NEW: begin
            new_in   = new_rank;
            state_in = S_UPD_SQ;
         end
         S_UPD_SQ: begin
            state_in = S_UPD_ACC;
         end
         S_UPD_ACC: begin
            delta_in = delta_sum[THR_W] ? {THR_W{1'b1}} : delta_sum[THR_W-1:0];
            if (node_last) begin
               state_in = S_PASS_END;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_UPD_RD;
            end
         end
         S_PASS_END: begin
            // passes_ff still counts the passes before this one.
            if (delta_ok || (passes_ff >= PASS_W'(max_iter_ff))) begin
               last_iter_in = passes_ff + 1'b1;
               last_conv_in = delta_ok;
               state_in     = S_RESP;
            end else begin
               passes_in = passes_ff + 1'b1;
               idx_in    = '0;
               dang_in   = '0;
               delta_in  = '0;
               state_in  = S_CLR_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load    = 1'b1;
               wipe_rsp_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_WIPE;
         idx_ff        <= '0;
         edge_count_ff <= '0;
         wipe_rsp_ff   <= 1'b0;
         last_iter_ff  <= '0;
         last_conv_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         edge_count_ff <= edge_count_in;
         wipe_rsp_ff   <= wipe_rsp_in;
         last_iter_ff  <= last_iter_in;
         last_conv_ff  <= last_conv_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      eidx_ff       <= eidx_in;
      src_ff        <= src_in;
      tgt_ff        <= tgt_in;
      init_ff       <= init_in;
      teleport_ff   <= teleport_in;
      dang_ff       <= dang_in;
      delta_ff      <= delta_in;
      old_ff        <= old_in;
      new_ff        <= new_in;
      passes_ff     <= passes_in;
      res_rank_ff   <= res_rank_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_rank_ff   <= res_rank_ff;
         rsp_iter_ff   <= last_iter_ff;
         rsp_conv_ff   <= last_conv_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.rank_value      = rsp_rank_ff;
   assign rsp_chan.iterations_done = rsp_iter_ff;
   assign rsp_chan.converged       = rsp_conv_ff;
   assign rsp_chan.status          = rsp_status_ff;

   pr_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_count_ff[EDGE_AW-1:0]),
      .wdata ({src_ff, tgt_ff}),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   pr_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
      .clock (clock),
      .we    (deg_we),
      .waddr (deg_waddr),
      .wdata (deg_wdata),
      .raddr (deg_raddr),
      .rdata (deg_rdata)
   );

   pr_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank_ram (
      .clock (clock),
      .we    (rank_we),
      .waddr (rank_waddr),
      .wdata (rank_wdata),
      .raddr (rank_raddr),
      .rdata (rank_rdata)
   );

   pr_ram #(.WIDTH(ACC_W), .DEPTH(MAX_NODES)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (acc_wdata),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   pr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // A quotient only ever arrives while the sequencer waits for one.
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_INIT || state_ff == S_DIV_TEL ||
                    state_ff == S_EDGE_DIV || state_ff == S_DIV_DANG))
      else $error("divider finished outside a wait state");

   // The edge count never runs past the store.
   a_edge_count_cap: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= EDGE_CAP)
      else $error("edge count beyond store size");

   // Every accepted item moves the sequencer out of the idle state in the cycle after it is taken.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != S_IDLE)
      else $error("item accepted without work");

   // The converged flag is only raised at the end of a pass.
   a_conv_at_pass_end: assert property (@(posedge clock) disable iff (reset)
      $rose(last_conv_ff) |-> $past(state_ff) == S_PASS_END)
      else $error("converged flag set outside pass end");

endmodule

`default_nettype wire

// ----- hw/rtl/pr_ram.sv -----
`default_nettype none

module pr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/pr_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is valid in
// the cycle in which done is high.
module pr_div import pr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [DEG_W-1:0]  divisor,
   output      logic              done,
   output      logic [DIV_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(DIV_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DEG_W-1:0]  rem_ff, rem_in;
   logic [DEG_W-1:0]  dsr_ff, dsr_in;
   logic [DEG_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         rem_in  = fits ? DEG_W'(trial - {1'b0, dsr_ff}) : trial[DEG_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
